// ===== hw/rtl/aes_pkg.sv =====
// aes_pkg: shared types, codes and constants of the anchored event scheduler
// used by aes_cell and anchored_event_scheduler, no dependencies
package aes_pkg;

    localparam int DEFAULT_SLOTS       = 8;
    localparam int MAX_RESULTS         = 8;
    localparam int CNT_W               = $clog2(MAX_RESULTS + 1);
    localparam int PIN_W               = 6;
    localparam int TID_W               = 8;
    localparam int WIDTH_W             = 32;
    localparam int TIME_W              = 64;
    localparam int SLOT_OUT_W          = 3;
    localparam logic [WIDTH_W-1:0] DEFAULT_PULSE_WIDTH = 32'd1000;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_OBS   = 2'd1;
    localparam logic [1:0] REQ_ARM   = 2'd2;
    localparam logic [1:0] REQ_DRAIN = 2'd3;

    localparam logic [1:0] SLOT_FREE  = 2'd0;
    localparam logic [1:0] SLOT_ARMED = 2'd1;
    localparam logic [1:0] SLOT_FIRED = 2'd2;

    localparam logic [1:0] KIND_ARM   = 2'd0;
    localparam logic [1:0] KIND_PULSE = 2'd1;
    localparam logic [1:0] KIND_NOTE  = 2'd2;

    localparam logic [1:0] ARM_OK        = 2'd0;
    localparam logic [1:0] ARM_NO_ANCHOR = 2'd1;
    localparam logic [1:0] ARM_FULL      = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] cnt;
        logic             found;
        logic             hit;
    } tok_t;

    typedef struct packed {
        logic [PIN_W-1:0]   pin;
        logic               pulse;
        logic [TID_W-1:0]   tid;
        logic [WIDTH_W-1:0] width;
        logic [TIME_W-1:0]  fire;
    } slot_data_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [1:0]            status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [PIN_W-1:0]      pin;
        logic [WIDTH_W-1:0]    width;
        logic [TID_W-1:0]      tid;
        logic [TIME_W-1:0]     fire;
        logic                  last;
    } res_t;

endpackage

// ===== hw/rtl/anchored_event_scheduler.sv =====
// anchored_event_scheduler: top level, request decode, time and anchor, result staging
// depends on aes_pkg and aes_cell
//
// One-shot event table with a microsecond time base. Each input beat is one request:
// a tick advances the counter and fires due slots, an observation begin latches the
// anchor, an arm takes the lowest free slot at anchor plus delay, and a drain reports
// and frees fired slots. Slots are a row of cells; a token walks the row one cell per
// cycle while the result channel does not stall it. At most eight results come from one
// beat and the final one carries m_last. The user must write the register through the
// cfg port only while the block is idle; the block itself does not enforce this.
module anchored_event_scheduler import aes_pkg::*; #(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [WIDTH_W-1:0]    cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [PIN_W-1:0]      s_pulse_pin,
    input  logic                  s_has_pulse,
    input  logic [TID_W-1:0]      s_timer_id,
    input  logic [WIDTH_W-1:0]    s_pulse_width,
    input  logic [31:0]           s_delay_after_anchor,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic [1:0]            m_arm_status,
    output logic [SLOT_OUT_W-1:0] m_slot_index,
    output logic [PIN_W-1:0]      m_out_pin,
    output logic [WIDTH_W-1:0]    m_out_width,
    output logic [TID_W-1:0]      m_out_timer_id,
    output logic [TIME_W-1:0]     m_fire_time,
    output logic                  m_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic               anchor_valid_reg, anchor_valid_next;
    logic [TIME_W-1:0]  anchor_reg, anchor_next;
    logic [WIDTH_W-1:0] dflt_width_reg, dflt_width_next;
    logic               launch_reg, launch_next;
    logic [1:0]         op_reg, op_next;
    slot_data_t         arm_reg, arm_next;
    logic               pend_valid_reg, pend_valid_next;
    res_t               pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    res_t               out_reg, out_next;

    tok_t               tok_vec [SLOTS];
    slot_data_t         data_vec [SLOTS];
    logic [SLOTS-1:0]   tok_valid_vec;
    tok_t               launch_tok;
    tok_t               tail;

    logic               in_acc;
    logic               out_free;
    logic               step;
    logic               tail_exit;
    logic               out_load;
    logic               hit;
    logic [IDX_W-1:0]   sel_idx;
    slot_data_t         sel_data;
    res_t               hit_res;

    assign launch_tok = '{valid: launch_reg, cnt: '0, found: 1'b0, hit: 1'b0};
    assign tail       = tok_vec[SLOTS-1];

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        tok_t cell_in;
        if (i == 0) begin : g_head
            assign cell_in = launch_tok;
        end else begin : g_body
            assign cell_in = tok_vec[i-1];
        end
        aes_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step     (step),
            .op       (op_reg),
            .now      (now_reg),
            .arm_in   (arm_reg),
            .tok_in   (cell_in),
            .tok_out  (tok_vec[i]),
            .data_out (data_vec[i])
        );
    end

    // pick the cell currently holding the token
    always_comb begin
        hit      = 1'b0;
        sel_idx  = '0;
        sel_data = '0;
        for (int i = 0; i < SLOTS; i++) begin
            tok_valid_vec[i] = tok_vec[i].valid;
            if (tok_vec[i].valid) begin
                hit      = tok_vec[i].hit;
                sel_idx  = IDX_W'(i);
                sel_data = data_vec[i];
            end
        end
    end

    always_comb begin
        hit_res      = '0;
        hit_res.slot = SLOT_OUT_W'(sel_idx);
        hit_res.fire = sel_data.fire;
        unique case (op_reg)
            REQ_TICK: begin
                hit_res.kind  = KIND_PULSE;
                hit_res.pin   = sel_data.pin;
                hit_res.width = sel_data.width;
                hit_res.tid   = sel_data.tid;
            end
            REQ_DRAIN: begin
                hit_res.kind = KIND_NOTE;
                hit_res.tid  = sel_data.tid;
            end
            default: begin
                hit_res.kind   = KIND_ARM;
                hit_res.status = ARM_OK;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign step      = !(hit && pend_valid_reg && !out_free);
    assign tail_exit = (state_reg == ST_SCAN) && tail.valid && step;

    always_comb begin
        state_next        = state_reg;
        now_next          = now_reg;
        anchor_valid_next = anchor_valid_reg;
        anchor_next       = anchor_reg;
        dflt_width_next   = dflt_width_reg;
        launch_next       = launch_reg;
        op_next           = op_reg;
        arm_next          = arm_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        out_load          = 1'b0;
        out_next          = out_reg;

        if (cfg_valid) begin
            dflt_width_next = cfg_data;
        end

        if (in_acc) begin
            op_next = s_req_type;
            unique case (s_req_type)
                REQ_TICK: begin
                    now_next    = now_reg + TIME_W'(1);
                    launch_next = 1'b1;
                    state_next  = ST_SCAN;
                end
                REQ_OBS: begin
                    anchor_valid_next = 1'b1;
                    anchor_next       = now_reg;
                end
                REQ_ARM: begin
                    if (!anchor_valid_reg) begin
                        pend_valid_next  = 1'b1;
                        pend_next        = '0;
                        pend_next.kind   = KIND_ARM;
                        pend_next.status = ARM_NO_ANCHOR;
                        state_next       = ST_FLUSH;
                    end else begin
                        arm_next.pin   = s_pulse_pin;
                        arm_next.pulse = s_has_pulse;
                        arm_next.tid   = s_timer_id;
                        arm_next.width = (s_pulse_width == '0) ? dflt_width_reg
                                                               : s_pulse_width;
                        arm_next.fire  = anchor_reg + {32'd0, s_delay_after_anchor};
                        launch_next    = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
                default: begin
                    launch_next = 1'b1;
                    state_next  = ST_SCAN;
                end
            endcase
        end

        if (launch_reg && step) begin
            launch_next = 1'b0;
        end

        // a result is held back until the next one shows whether it was the last
        if (hit && step) begin
            if (pend_valid_reg) begin
                out_load      = 1'b1;
                out_next      = pend_reg;
                out_next.last = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = hit_res;
        end

        if (tail_exit) begin
            state_next = ST_FLUSH;
            if (op_reg == REQ_ARM && !tail.found) begin
                pend_valid_next  = 1'b1;
                pend_next        = '0;
                pend_next.kind   = KIND_ARM;
                pend_next.status = ARM_FULL;
            end
        end

        if (state_reg == ST_FLUSH) begin
            if (!pend_valid_reg) begin
                state_next = ST_IDLE;
            end else if (out_free) begin
                out_load        = 1'b1;
                out_next        = pend_reg;
                out_next.last   = 1'b1;
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            now_reg          <= '0;
            anchor_valid_reg <= 1'b0;
            anchor_reg       <= '0;
            dflt_width_reg   <= DEFAULT_PULSE_WIDTH;
            launch_reg       <= 1'b0;
            op_reg           <= REQ_TICK;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            now_reg          <= now_next;
            anchor_valid_reg <= anchor_valid_next;
            anchor_reg       <= anchor_next;
            dflt_width_reg   <= dflt_width_next;
            launch_reg       <= launch_next;
            op_reg           <= op_next;
            pend_valid_reg   <= pend_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        arm_reg  <= arm_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = out_reg.kind;
    assign m_arm_status   = out_reg.status;
    assign m_slot_index   = out_reg.slot;
    assign m_out_pin      = out_reg.pin;
    assign m_out_width    = out_reg.width;
    assign m_out_timer_id = out_reg.tid;
    assign m_fire_time    = out_reg.fire;
    assign m_last         = out_reg.last;

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({launch_reg, tok_valid_vec}))
        else $error("more than one token in the slot row");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (tok_valid_vec == '0 && !launch_reg && !pend_valid_reg))
        else $error("request beat taken while a scan or held result is in flight");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register loaded while its beat is still waiting");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_next.last) |=> (state_reg == ST_IDLE))
        else $error("final result beat staged before the request finished");

endmodule

// ===== hw/rtl/aes_cell.sv =====
// aes_cell: one slot of the event table, with its status, stored event and token stage
// depends on aes_pkg
module aes_cell import aes_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [1:0]  op,
    input  logic [TIME_W-1:0] now,
    input  slot_data_t  arm_in,
    input  tok_t        tok_in,
    output tok_t        tok_out,
    output slot_data_t  data_out
);

    logic [1:0] status_reg;
    logic [1:0] status_next;
    tok_t       tok_reg;
    tok_t       tok_next;
    slot_data_t data_reg;
    logic       claim;

    always_comb begin
        tok_next     = tok_in;
        tok_next.hit = 1'b0;
        status_next  = status_reg;
        claim        = 1'b0;
        if (tok_in.valid) begin
            unique case (op)
                REQ_TICK: begin
                    if (status_reg == SLOT_ARMED && data_reg.fire <= now
                        && tok_in.cnt < CNT_W'(MAX_RESULTS)) begin
                        status_next  = SLOT_FIRED;
                        tok_next.cnt = tok_in.cnt + CNT_W'(data_reg.pulse);
                        tok_next.hit = data_reg.pulse;
                    end
                end
                REQ_ARM: begin
                    if (status_reg == SLOT_FREE && !tok_in.found) begin
                        claim          = 1'b1;
                        status_next    = SLOT_ARMED;
                        tok_next.found = 1'b1;
                        tok_next.hit   = 1'b1;
                    end
                end
                REQ_DRAIN: begin
                    if (status_reg == SLOT_FIRED && tok_in.cnt < CNT_W'(MAX_RESULTS)) begin
                        status_next  = SLOT_FREE;
                        tok_next.cnt = tok_in.cnt + CNT_W'(1);
                        tok_next.hit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= SLOT_FREE;
            tok_reg    <= '0;
        end else if (step) begin
            status_reg <= status_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && claim) begin
            data_reg <= arm_in;
        end
    end

    assign tok_out  = tok_reg;
    assign data_out = data_reg;

endmodule
